// ===== src/bba_pkg.sv =====
`timescale 1ns / 1ps

package bba_pkg;

   localparam int MAX_BLOCKS = 65536;
   localparam int WORD_BITS  = 32;

   localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int WCNT_W     = $clog2(MAP_WORDS + 1);
   localparam int BPOS_W     = $clog2(WORD_BITS);
   localparam int BLOCK_W    = 16;
   localparam int COUNT_W    = 17;
   localparam int ACTION_W   = 3;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int IDX_W      = (WCNT_W > COUNT_W) ? WCNT_W : COUNT_W;
   localparam int TMAX       = (MAX_BLOCKS < 65536) ? MAX_BLOCKS : 65536;

   localparam logic [COUNT_W-1:0] TOTAL_RESET    = COUNT_W'(65536);
   localparam logic [COUNT_W-1:0] RESERVED_RESET = '0;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED = CSR_IDX_W'(1);

   localparam logic [ACTION_W-1:0] ACT_READ   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_ALLOC  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_FREE   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_FORMAT = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [BLOCK_W-1:0]  block_number;
      logic                bit_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BLOCK_W-1:0]  result_block;
      logic                bit_read;
      logic [COUNT_W-1:0]  free_count;
   } rsp_type;

   typedef struct packed {
      logic take;
      logic rd_blk;
      logic modify;
      logic scan;
      logic fmt_sweep;
      logic clr_sweep;
      logic res_nofree;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                count_zero;
      logic                scan_hit;
      logic                scan_end;
      logic                sweep_last;
      logic                rsp_free;
   } stat_type;

endpackage

// ===== src/bba_ctrl.sv =====
`timescale 1ns / 1ps

module bba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bba_pkg::stat_type stat,
   output bba_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_MODIFY,
      S_SCAN,
      S_FORMAT,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.action)
               bba_pkg::ACT_ALLOC: begin
                  if (stat.count_zero) begin
                     cmd.res_nofree = 1'b1;
                     state_in       = S_FINISH;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               bba_pkg::ACT_FORMAT: begin
                  state_in = S_FORMAT;
               end
               default: begin
                  cmd.rd_blk = 1'b1;
                  state_in   = S_MODIFY;
               end
            endcase
         end
         S_MODIFY: begin
            cmd.modify = 1'b1;
            state_in   = S_FINISH;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_hit || stat.scan_end) begin
               state_in = S_FINISH;
            end
         end
         S_FORMAT: begin
            cmd.fmt_sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/bba_datapath.sv =====
`timescale 1ns / 1ps

module bba_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  bba_pkg::req_type                    req_data,
   output bba_pkg::rsp_type                    rsp_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                csr_we,
   input  logic [bba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bba_pkg::COUNT_W-1:0]         csr_wdata,
   input  bba_pkg::cmd_type                    cmd,
   output bba_pkg::stat_type                   stat
);

   localparam int WB = bba_pkg::WORD_BITS;
   localparam int BP = bba_pkg::BPOS_W;
   localparam int IW = bba_pkg::IDX_W;
   localparam int CW = bba_pkg::COUNT_W;

   function automatic logic [WB-1:0] prefix_mask(input logic [IW-1:0] word_idx,
                                                 input logic [IW-1:0] limit);
      logic [IW-1:0] full_words;
      logic [BP-1:0] rem;
      full_words = limit >> BP;
      rem        = limit[BP-1:0];
      if (word_idx < full_words) begin
         prefix_mask = '1;
      end else if (word_idx == full_words) begin
         prefix_mask = (WB'(1) << rem) - WB'(1);
      end else begin
         prefix_mask = '0;
      end
   endfunction

   function automatic logic [BP-1:0] lowest_set(input logic [WB-1:0] v);
      lowest_set = '0;
      for (int i = WB - 1; i >= 0; i--) begin
         if (v[i]) begin
            lowest_set = BP'(i);
         end
      end
   endfunction

   logic [WB-1:0]                   map_mem [bba_pkg::MAP_WORDS];
   logic [WB-1:0]                   rdata_ff;
   logic [bba_pkg::WIDX_W-1:0]      ridx_ff;
   logic                            rvalid_ff;
   logic [bba_pkg::WCNT_W-1:0]      widx_ff;
   bba_pkg::req_type                item_ff;
   logic [CW-1:0]                   total_ff;
   logic [CW-1:0]                   reserved_ff;
   logic [CW-1:0]                   free_ff;
   logic [bba_pkg::STATUS_W-1:0]    res_status_ff;
   logic [bba_pkg::BLOCK_W-1:0]     res_block_ff;
   logic                            res_bit_ff;
   bba_pkg::rsp_type                rsp_ff;
   logic                            rsp_valid_ff;

   logic [CW-1:0]                   t_eff;
   logic [CW-1:0]                   r_eff;
   logic [IW-1:0]                   n_words;
   logic                            more;
   logic                            in_range;
   logic [bba_pkg::WIDX_W-1:0]      item_word;
   logic [BP-1:0]                   item_pos;
   logic                            item_bit;
   logic [WB-1:0]                   zero_bits;
   logic                            hit;
   logic [BP-1:0]                   hit_pos;
   logic                            sweep_last;
   logic                            mem_we;
   logic [bba_pkg::WIDX_W-1:0]      mem_waddr;
   logic [WB-1:0]                   mem_wdata;
   logic                            mem_re;
   logic [bba_pkg::WIDX_W-1:0]      mem_raddr;
   logic                            bit_change;
   logic [WB-1:0]                   changed_word;

   assign t_eff     = (total_ff > CW'(bba_pkg::TMAX)) ? CW'(bba_pkg::TMAX) : total_ff;
   assign r_eff     = (reserved_ff < t_eff) ? reserved_ff : t_eff;
   assign n_words   = (IW'(t_eff) + IW'(WB - 1)) >> BP;
   assign more      = IW'(widx_ff) < n_words;
   assign in_range  = CW'(item_ff.block_number) < t_eff;
   assign item_word = bba_pkg::WIDX_W'(item_ff.block_number >> BP);
   assign item_pos  = item_ff.block_number[BP-1:0];
   assign item_bit  = rdata_ff[item_pos];
   assign zero_bits = ~rdata_ff & prefix_mask(IW'(ridx_ff), IW'(t_eff));
   assign hit       = rvalid_ff && (zero_bits != '0);
   assign hit_pos   = lowest_set(zero_bits);
   assign sweep_last = widx_ff == bba_pkg::WCNT_W'(bba_pkg::MAP_WORDS - 1);

   assign bit_change = cmd.modify && in_range &&
                       (item_ff.action == bba_pkg::ACT_WRITE ||
                        item_ff.action == bba_pkg::ACT_FREE);

   always_comb begin
      changed_word = rdata_ff;
      changed_word[item_pos] = (item_ff.action == bba_pkg::ACT_WRITE) ? item_ff.bit_value
                                                                     : 1'b0;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = widx_ff[bba_pkg::WIDX_W-1:0];
      mem_wdata = '0;
      if (cmd.clr_sweep) begin
         mem_we = 1'b1;
      end else if (cmd.fmt_sweep) begin
         mem_we    = 1'b1;
         mem_wdata = prefix_mask(IW'(widx_ff), IW'(r_eff));
      end else if (bit_change) begin
         mem_we    = 1'b1;
         mem_waddr = item_word;
         mem_wdata = changed_word;
      end else if (cmd.scan && hit) begin
         mem_we    = 1'b1;
         mem_waddr = ridx_ff;
         mem_wdata = rdata_ff | (WB'(1) << hit_pos);
      end
   end

   assign mem_re    = cmd.rd_blk || (cmd.scan && more);
   assign mem_raddr = cmd.rd_blk ? item_word : widx_ff[bba_pkg::WIDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= map_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else if (cmd.take) begin
         widx_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (cmd.clr_sweep || cmd.fmt_sweep || (cmd.scan && more)) begin
            widx_ff <= widx_ff + bba_pkg::WCNT_W'(1);
         end
         rvalid_ff <= cmd.scan && more;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && more) begin
         ridx_ff <= widx_ff[bba_pkg::WIDX_W-1:0];
      end
      if (cmd.take) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= bba_pkg::TOTAL_RESET;
         reserved_ff <= bba_pkg::RESERVED_RESET;
      end else if (csr_we) begin
         case (csr_index)
            bba_pkg::CSR_TOTAL:    total_ff    <= csr_wdata;
            bba_pkg::CSR_RESERVED: reserved_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '0;
      end else if (cmd.modify && in_range && item_ff.action == bba_pkg::ACT_FREE) begin
         if (free_ff < t_eff) begin
            free_ff <= free_ff + CW'(1);
         end
      end else if (cmd.scan && hit) begin
         free_ff <= free_ff - CW'(1);
      end else if (cmd.fmt_sweep && sweep_last) begin
         free_ff <= t_eff - r_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.modify) begin
         res_block_ff <= item_ff.block_number;
         case (item_ff.action)
            bba_pkg::ACT_READ: begin
               res_status_ff <= in_range ? bba_pkg::ST_OK : bba_pkg::ST_RANGE;
               res_bit_ff    <= in_range && item_bit;
            end
            bba_pkg::ACT_WRITE: begin
               res_status_ff <= in_range ? bba_pkg::ST_OK : bba_pkg::ST_RANGE;
               res_bit_ff    <= in_range && item_ff.bit_value;
            end
            bba_pkg::ACT_FREE: begin
               res_status_ff <= in_range ? bba_pkg::ST_OK : bba_pkg::ST_RANGE;
               res_bit_ff    <= 1'b0;
            end
            default: begin
               res_status_ff <= bba_pkg::ST_OK;
               res_bit_ff    <= in_range && item_bit;
            end
         endcase
      end else if (cmd.scan && hit) begin
         res_status_ff <= bba_pkg::ST_OK;
         res_block_ff  <= bba_pkg::BLOCK_W'((IW'(ridx_ff) << BP) | IW'(hit_pos));
         res_bit_ff    <= 1'b1;
      end else if (cmd.res_nofree || (cmd.scan && !rvalid_ff && !more)) begin
         res_status_ff <= bba_pkg::ST_NOFREE;
         res_block_ff  <= '0;
         res_bit_ff    <= 1'b0;
      end else if (cmd.fmt_sweep && sweep_last) begin
         res_status_ff <= bba_pkg::ST_OK;
         res_block_ff  <= item_ff.block_number;
         res_bit_ff    <= in_range && (CW'(item_ff.block_number) < r_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.status       <= res_status_ff;
         rsp_ff.result_block <= res_block_ff;
         rsp_ff.bit_read     <= res_bit_ff;
         rsp_ff.free_count   <= free_ff;
      end
   end

   assign rsp_data = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   assign stat.action     = item_ff.action;
   assign stat.count_zero = free_ff == '0;
   assign stat.scan_hit   = hit;
   assign stat.scan_end   = !rvalid_ff && !more;
   assign stat.sweep_last = sweep_last;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

// ===== src/block_bitmap_allocator_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  bba_pkg::req_type
// rsp_      out        rsp_valid / rsp_ready  bba_pkg::rsp_type
// csr_      in         csr_we                 csr_index, csr_wdata
//
// Read, write, free and unused codes pass the dispatch, modify and finish states.
// Allocate walks the map through the single map memory read port until it finds a free
// bit or reaches the end; format writes every map word (2048 with the defaults).
// After reset a clearing pass writes every map word once, with no request accepted;
// configuration writes are taken throughout.
// A held response stalls only the final step; the next request can then already wait.

module block_bitmap_allocator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bba_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bba_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [bba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bba_pkg::COUNT_W-1:0]   csr_wdata
);

   bba_pkg::cmd_type  cmd;
   bba_pkg::stat_type stat;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bba_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// ===== src/bba_checker.sv =====
`timescale 1ns / 1ps

module bba_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bba_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during clearing pass");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in progress");

   a_nofree_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == bba_pkg::ST_NOFREE |->
         rsp_data.result_block == '0 && !rsp_data.bit_read)
      else $error("no-free response carries a block");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.free_count <= bba_pkg::COUNT_W'(bba_pkg::TMAX))
      else $error("free count beyond map size");

endmodule

bind block_bitmap_allocator_core bba_checker u_checker (.*);
